FILE: rtl/dtbr_pkg.sv
// ----------------------------------------------------------------------------
// dtbr_pkg: shared types and constants for the dual-table bit remapper
// Table geometry, command codes, sequencer states and default table contents.
// ----------------------------------------------------------------------------
package dtbr_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int LIM_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int TGT_W         = 7;
  localparam int MAP_W         = 128;
  localparam int HALF_W        = 64;
  localparam int ALT_OFFSET    = 64;
  localparam int ENTRY_W       = 2 * TGT_W;

  // field widths
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] OUT_OF_RANGE = 8'hFF;
  localparam logic [BYTE_W-1:0] CNT_RESET    = 8'd128;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_REMAP = 2'd0,
    CMD_SET   = 2'd1,
    CMD_GET   = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_FIN,
    S_EXEC,
    S_GET,
    S_DONE
  } state_t;

  // default table entry: identity for normal, half-rotation for alternate
  function automatic logic [TGT_W-1:0] def_target(input logic alt,
                                                  input logic [IDX_W-1:0] idx);
    logic [TGT_W-1:0] base;
    base = TGT_W'(idx);
    return alt ? (base + TGT_W'(ALT_OFFSET)) : base;
  endfunction

endpackage

FILE: rtl/dtbr_in_if.sv
// ----------------------------------------------------------------------------
// dtbr_in_if: input item channel
// Valid/ready handshake with the command and bitmap payload.
// ----------------------------------------------------------------------------
interface dtbr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        alt_mode;
  logic [63:0] bits_low;
  logic [63:0] bits_high;
  logic [7:0]  source_index;
  logic [7:0]  target_normal;
  logic [7:0]  target_alt;

  modport source (output valid, command, alt_mode, bits_low, bits_high, source_index,
                  target_normal, target_alt, input ready);
  modport sink (input valid, command, alt_mode, bits_low, bits_high, source_index,
                target_normal, target_alt, output ready);
endinterface

FILE: rtl/dtbr_out_if.sv
// ----------------------------------------------------------------------------
// dtbr_out_if: result item channel
// Valid/ready handshake with the remapped bitmap, read-back and status.
// ----------------------------------------------------------------------------
interface dtbr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] mapped_low;
  logic [63:0] mapped_high;
  logic [7:0]  read_normal;
  logic [7:0]  read_alt;
  logic        status;

  modport source (output valid, mapped_low, mapped_high, read_normal, read_alt, status,
                  input ready);
  modport sink (input valid, mapped_low, mapped_high, read_normal, read_alt, status,
                output ready);
endinterface

FILE: rtl/dtbr_ram.sv
// ----------------------------------------------------------------------------
// dtbr_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dual_table_bit_remap_core.sv
// ----------------------------------------------------------------------------
// dual_table_bit_remap_core: programmable two-table bit remap crossbar
//
//   channel   direction  handshake      contents
//   in_chan   sink       valid/ready    command, alt_mode, bitmap, index, targets
//   out_chan  source     valid/ready    mapped bitmap, read-back pair, status
//   cfg_*     input      write enable   max_source_count
//
// A remap walks the source bitmap one bit per cycle, reading one table entry
// per cycle from the table RAM; it walks min(max_source_count, 128) bits and
// then passes S_FIN and S_DONE. Set and table reset pass S_EXEC and S_DONE,
// a get in range also S_GET. Entries carry a valid bit, so reset and the table
// reset command restore the defaults at once. A finished result waits in the
// output register while the next item is taken in; a stalled result holds the
// sequencer only when a second result is ready behind it.
// ----------------------------------------------------------------------------
module dual_table_bit_remap_core
  import dtbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  dtbr_in_if.sink           in_chan,
  dtbr_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata
);

  // configuration and control
  logic [BYTE_W-1:0]        mcnt_r;
  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r;
  logic                     alt_r;
  logic [BYTE_W-1:0]        idx_r, tn_r, ta_r;
  logic [LIM_W-1:0]         cnt_r, cnt_nxt, lim_r;
  logic [MAP_W-1:0]         src_r, src_nxt;
  logic [MAP_W-1:0]         res_r, res_nxt;
  logic [BYTE_W-1:0]        rdn_r, rdn_nxt, rda_r, rda_nxt;
  logic                     stat_r, stat_nxt;
  logic                     pend_r, pend_nxt, pbit_r, pbit_nxt;
  logic [IDX_W-1:0]         pidx_r, pidx_nxt;
  logic [TABLE_ENTRIES-1:0] vld_r, vld_nxt;
  logic                     accept;
  logic [LIM_W-1:0]         lim_in;

  // output register
  logic                     ovld_r, ovld_nxt;
  logic [MAP_W-1:0]         omap_r;
  logic [BYTE_W-1:0]        ordn_r, orda_r;
  logic                     ostat_r;
  logic                     load_out;

  // table RAM: normal target in the upper half, alternate in the lower
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic [TGT_W-1:0]         cur_n, cur_a, tgt;
  logic                     set_ok;

  dtbr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign lim_in        = (mcnt_r > BYTE_W'(TABLE_ENTRIES)) ? LIM_W'(TABLE_ENTRIES)
                                                          : LIM_W'(mcnt_r);

  // entry read back, default where never written since reset
  assign cur_n = vld_r[pidx_r] ? ram_rdata[ENTRY_W-1:TGT_W] : def_target(1'b0, pidx_r);
  assign cur_a = vld_r[pidx_r] ? ram_rdata[TGT_W-1:0] : def_target(1'b1, pidx_r);
  assign tgt   = alt_r ? cur_a : cur_n;

  assign set_ok = (idx_r < BYTE_W'(TABLE_ENTRIES)) && (tn_r < CNT_RESET)
                  && (ta_r < CNT_RESET);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= CNT_RESET;
    end else if (cfg_we) begin
      mcnt_r <= cfg_wdata;
    end
  end

  // state register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      vld_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      vld_r   <= vld_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // item payload and work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_chan.command);
      alt_r <= in_chan.alt_mode;
      idx_r <= in_chan.source_index;
      tn_r  <= in_chan.target_normal;
      ta_r  <= in_chan.target_alt;
      lim_r <= lim_in;
    end
    cnt_r  <= cnt_nxt;
    src_r  <= src_nxt;
    res_r  <= res_nxt;
    rdn_r  <= rdn_nxt;
    rda_r  <= rda_nxt;
    stat_r <= stat_nxt;
    pbit_r <= pbit_nxt;
    pidx_r <= pidx_nxt;
    if (load_out) begin
      omap_r  <= res_r;
      ordn_r  <= rdn_r;
      orda_r  <= rda_r;
      ostat_r <= stat_r;
    end
  end

  // next state and datapath control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    src_nxt   = src_r;
    res_nxt   = res_r;
    rdn_nxt   = rdn_r;
    rda_nxt   = rda_r;
    stat_nxt  = stat_r;
    pend_nxt  = 1'b0;
    pbit_nxt  = pbit_r;
    pidx_nxt  = pidx_r;
    vld_nxt   = vld_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = {tn_r[TGT_W-1:0], ta_r[TGT_W-1:0]};
    ram_raddr = idx_r[IDX_W-1:0];
    load_out  = 1'b0;

    // scatter the pending source bit into the result bitmap
    if (pend_r && pbit_r) begin
      res_nxt = res_r | (MAP_W'(1) << tgt);
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          src_nxt   = {in_chan.bits_high, in_chan.bits_low};
          res_nxt   = '0;
          rdn_nxt   = '0;
          rda_nxt   = '0;
          stat_nxt  = 1'b0;
          state_nxt = (cmd_t'(in_chan.command) == CMD_REMAP) ? S_RUN : S_EXEC;
        end
      end
      S_RUN: begin
        // one source bit and one table read per cycle
        ram_raddr = cnt_r[IDX_W-1:0];
        if (cnt_r < lim_r) begin
          pend_nxt = 1'b1;
          pbit_nxt = src_r[0];
          pidx_nxt = cnt_r[IDX_W-1:0];
          src_nxt  = src_r >> 1;
          cnt_nxt  = cnt_r + LIM_W'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_DONE;
      end
      S_EXEC: begin
        pidx_nxt = idx_r[IDX_W-1:0];
        case (cmd_r)
          CMD_SET: begin
            if (set_ok) begin
              ram_we                    = 1'b1;
              vld_nxt[idx_r[IDX_W-1:0]] = 1'b1;
            end else begin
              stat_nxt = 1'b1;
            end
            state_nxt = S_DONE;
          end
          CMD_GET: begin
            if (idx_r < BYTE_W'(TABLE_ENTRIES)) begin
              state_nxt = S_GET;
            end else begin
              rdn_nxt   = OUT_OF_RANGE;
              rda_nxt   = OUT_OF_RANGE;
              state_nxt = S_DONE;
            end
          end
          default: begin
            vld_nxt   = '0;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_GET: begin
        rdn_nxt   = BYTE_W'(cur_n);
        rda_nxt   = BYTE_W'(cur_a);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovld_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // output valid
    ovld_nxt = load_out ? 1'b1 : (ovld_r && !out_chan.ready);
  end

  // result channel
  assign out_chan.valid       = ovld_r;
  assign out_chan.mapped_low  = omap_r[HALF_W-1:0];
  assign out_chan.mapped_high = omap_r[MAP_W-1:HALF_W];
  assign out_chan.read_normal = ordn_r;
  assign out_chan.read_alt    = orda_r;
  assign out_chan.status      = ostat_r;

  // a new result only follows a finished item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(ovld_r) || $past(out_chan.ready)) && ovld_r |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished item");

  // reject status only from a set
  a_stat_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && stat_r |-> (cmd_r == CMD_SET))
    else $error("reject status on a non-set command");

  // no scatter pending while waiting for an item
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("table read pending in idle");

  // walk counter stays within the source limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r <= lim_r))
    else $error("source walk ran past its limit");

  // only a remap produces a bitmap
  a_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (cmd_r != CMD_REMAP) |-> (res_r == '0))
    else $error("non-remap command left bitmap bits set");

endmodule
